>>> design/asc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Analog sample conditioner package
// Shared constants, register codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned PERMILLE        = 1000;
  localparam int unsigned RING_DEPTH      = 3;
  localparam int unsigned ALPHA_W         = 10;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CLAMP_MAX_RST   = 1023;
  localparam int unsigned SMOOTH_RST      = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLAMP_MIN  = 3'd0,
    REG_CLAMP_MAX  = 3'd1,
    REG_SMOOTHING  = 3'd2,
    REG_HYSTERESIS = 3'd3,
    REG_DEADBAND   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV_PROD,
    ST_SUM,
    ST_DIV_SUM,
    ST_BAND
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic mul;
    logic sum;
    logic take_avg;
    logic band;
  } dp_cmd_t;

  typedef struct packed {
    logic avg_started;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

>>> design/asc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample input channel
// Carries one converter sample and the caller's previous output per transfer.
// ----------------------------------------------------------------------------
interface asc_in_if import asc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;
  logic [SAMPLE_BITS:0]   previous_output;

  modport source (output valid, raw_sample, previous_output, input ready);
  modport sink   (input valid, raw_sample, previous_output, output ready);
endinterface

>>> design/asc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output channel
// Carries one conditioned value per transfer.
// ----------------------------------------------------------------------------
interface asc_out_if import asc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_BITS:0] conditioned_value;

  modport source (output valid, conditioned_value, input ready);
  modport sink   (input valid, conditioned_value, output ready);
endinterface

>>> design/asc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the write data per transfer.
// ----------------------------------------------------------------------------
interface asc_cfg_if import asc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  localparam int unsigned DATA_W = (SAMPLE_BITS + 1 > ALPHA_W) ? SAMPLE_BITS + 1 : ALPHA_W;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/analog_sample_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Analog sample conditioner
// Clamp, median of three, exponential average in thousandths, hysteresis
// against the caller's previous output and a deadband against the last
// committed value.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. The first sample after reset loads the
// average directly, without a division. Every later sample passes twice
// through the divide-by-1000 unit, a reciprocal multiplication (once to
// scale the old average, once to take the integer part of the new one).
// The result sits in an output register, so a new sample is taken while it
// waits to be collected.
// Configuration writes are taken in any cycle and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module analog_sample_conditioner import asc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  asc_in_if.sink    sample_i,
  asc_out_if.source result_o,
  asc_cfg_if.sink   cfg_i
);

  logic [SAMPLE_BITS-1:0] clamp_min_q;
  logic [SAMPLE_BITS-1:0] clamp_max_q;
  logic [ALPHA_W-1:0]     smoothing_q;
  logic [SAMPLE_BITS:0]   hysteresis_q;
  logic [SAMPLE_BITS:0]   deadband_q;
  logic                   cfg_write;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  // Register file; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_min_q  <= '0;
      clamp_max_q  <= SAMPLE_BITS'(CLAMP_MAX_RST);
      smoothing_q  <= ALPHA_W'(SMOOTH_RST);
      hysteresis_q <= '0;
      deadband_q   <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_CLAMP_MIN:  clamp_min_q  <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_CLAMP_MAX:  clamp_max_q  <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_SMOOTHING:  smoothing_q  <= cfg_i.data[ALPHA_W-1:0];
        REG_HYSTERESIS: hysteresis_q <= cfg_i.data[SAMPLE_BITS:0];
        REG_DEADBAND:   deadband_q   <= cfg_i.data[SAMPLE_BITS:0];
        default: begin
          clamp_min_q <= clamp_min_q;
        end
      endcase
    end
  end

  asc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  asc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .raw_sample_i        (sample_i.raw_sample),
    .previous_output_i   (sample_i.previous_output),
    .clamp_min_i         (clamp_min_q),
    .clamp_max_i         (clamp_max_q),
    .smoothing_i         (smoothing_q),
    .hysteresis_i        (hysteresis_q),
    .deadband_i          (deadband_q),
    .out_ready_i         (result_o.ready),
    .out_valid_o         (result_o.valid),
    .conditioned_value_o (result_o.conditioned_value)
  );

endmodule

>>> design/asc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divide by one thousand
// Reciprocal multiplication by the constant 1000, split into two partial
// products that are registered and then summed.
// ----------------------------------------------------------------------------
module asc_div import asc_pkg::*; #(
  parameter int unsigned DIV_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  // floor(x / 1000) equals (x * RECIP) >> SHIFT for every x below 2^DIV_W,
  // because the rounding error of RECIP times x stays below 2^SHIFT.
  localparam int unsigned SHIFT   = DIV_W + $clog2(PERMILLE);
  localparam int unsigned RECIP_W = DIV_W + 1;
  localparam int unsigned LO_W    = (RECIP_W + 1) / 2;
  localparam int unsigned HI_W    = RECIP_W - LO_W;
  localparam int unsigned LO_P_W  = DIV_W + LO_W;
  localparam int unsigned HI_P_W  = DIV_W + HI_W;
  localparam int unsigned FULL_W  = DIV_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(PERMILLE - 1)) / 64'(PERMILLE));
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:LO_W];

  logic              mul_q;
  logic              sum_q;
  logic [DIV_W-1:0]  x_q;
  logic [LO_P_W-1:0] lo_q, lo_d;
  logic [HI_P_W-1:0] hi_q, hi_d;
  logic [FULL_W-1:0] full;
  logic [DIV_W-1:0]  quot_q, quot_d;

  assign lo_d   = LO_P_W'(x_q) * LO_P_W'(RECIP_LO);
  assign hi_d   = HI_P_W'(x_q) * HI_P_W'(RECIP_HI);
  assign full   = (FULL_W'(hi_q) << LO_W) + FULL_W'(lo_q);
  assign quot_d = DIV_W'(full[FULL_W-1:SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= 1'b0;
      sum_q <= 1'b0;
    end else begin
      mul_q <= start_i;
      sum_q <= mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
    end
    if (mul_q) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (sum_q) begin
      quot_q <= quot_d;
    end
  end

  assign done_o     = !mul_q && !sum_q;
  assign quotient_o = quot_q;

  a_start_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> done_o)
    else $error("Division started while the previous one was still running.");

  a_single_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_q && sum_q))
    else $error("Two divisions overlapped in the pipeline.");

endmodule

>>> design/asc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditioner datapath
// Clamp, median ring, exponential average arithmetic, banding and the
// output register.
// ----------------------------------------------------------------------------
module asc_dp import asc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  input  logic [SAMPLE_BITS:0]   previous_output_i,
  input  logic [SAMPLE_BITS-1:0] clamp_min_i,
  input  logic [SAMPLE_BITS-1:0] clamp_max_i,
  input  logic [ALPHA_W-1:0]     smoothing_i,
  input  logic [SAMPLE_BITS:0]   hysteresis_i,
  input  logic [SAMPLE_BITS:0]   deadband_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [SAMPLE_BITS:0]   conditioned_value_o
);

  localparam int unsigned VAL_W  = SAMPLE_BITS + 1;
  localparam int unsigned AVG_W  = SAMPLE_BITS + ALPHA_W;
  localparam int unsigned PROD_W = AVG_W + ALPHA_W;
  localparam int unsigned DIV_W  = PROD_W;
  localparam logic [VAL_W-1:0] TOP_VALUE = {1'b1, {SAMPLE_BITS{1'b0}}};

  function automatic logic [VAL_W-1:0] mid_of_three(logic [VAL_W-1:0] x,
                                                    logic [VAL_W-1:0] y,
                                                    logic [VAL_W-1:0] z);
    logic [VAL_W-1:0] m;
    if ((x >= y && x <= z) || (x >= z && x <= y)) begin
      m = x;
    end else if ((y >= x && y <= z) || (y >= z && y <= x)) begin
      m = y;
    end else begin
      m = z;
    end
    return m;
  endfunction

  function automatic logic [VAL_W-1:0] abs_diff(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  // Input capture
  logic [SAMPLE_BITS-1:0] raw_q;
  logic [VAL_W-1:0]       prev_q;

  // Median ring
  logic [VAL_W-1:0] ring_q [RING_DEPTH];
  logic [1:0]       ring_pos_q, ring_pos_d;
  logic [1:0]       ring_fill_q, ring_fill_d;
  logic [VAL_W-1:0] clamped;
  logic [VAL_W-1:0] ring_view [RING_DEPTH];
  logic [VAL_W-1:0] filtered_q, filtered_d;

  // Average
  logic [ALPHA_W-1:0] alpha_cap;
  logic [ALPHA_W-1:0] keep;
  logic [PROD_W-1:0]  prod;
  logic [AVG_W-1:0]   fa_q;
  logic [AVG_W-1:0]   avg_s_q;
  logic [AVG_W-1:0]   avg_new;
  logic               avg_started_q;
  logic [VAL_W-1:0]   avg_val_q;

  // Divider
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  // Banding and output
  logic             commit_started_q;
  logic [VAL_W-1:0] committed_q;
  logic             within_hyst;
  logic             within_dead;
  logic [VAL_W-1:0] result_d;
  logic             take_avg_commit;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_data_q;

  // Clamp; the lower limit wins when the limits cross.
  always_comb begin
    if (raw_q <= clamp_min_i) begin
      clamped = '0;
    end else if (raw_q >= clamp_max_i) begin
      clamped = TOP_VALUE;
    end else begin
      clamped = {1'b0, raw_q};
    end
  end

  // The ring as it looks once the new sample has gone in.
  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_view[i] = (ring_pos_q == 2'(i)) ? clamped : ring_q[i];
    end
  end

  assign filtered_d  = (ring_fill_q >= 2'(RING_DEPTH - 1))
                     ? mid_of_three(ring_view[0], ring_view[1], ring_view[2])
                     : clamped;
  assign ring_pos_d  = (ring_pos_q == 2'(RING_DEPTH - 1)) ? 2'd0 : ring_pos_q + 2'd1;
  assign ring_fill_d = (ring_fill_q < 2'(RING_DEPTH)) ? ring_fill_q + 2'd1 : ring_fill_q;

  // new = f*alpha + floor(avg*(1000-alpha)/1000), which equals the full
  // update because f*1000*alpha is a whole multiple of 1000.
  assign alpha_cap = (smoothing_i > ALPHA_W'(PERMILLE)) ? ALPHA_W'(PERMILLE) : smoothing_i;
  assign keep      = ALPHA_W'(PERMILLE) - alpha_cap;
  assign prod      = PROD_W'(avg_s_q) * PROD_W'(keep);
  assign avg_new   = fa_q + AVG_W'(div_quot);

  assign div_start    = (cmd_i.mul && avg_started_q) || cmd_i.sum;
  assign div_dividend = cmd_i.sum ? DIV_W'(avg_new) : DIV_W'(prod);

  asc_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Banding against the caller's output and then the committed value.
  assign within_hyst = abs_diff(avg_val_q, prev_q) <= hysteresis_i;
  assign within_dead = abs_diff(avg_val_q, committed_q) <= deadband_i;

  always_comb begin
    take_avg_commit = 1'b0;
    if (within_hyst) begin
      result_d = prev_q;
    end else if (!commit_started_q || !within_dead) begin
      result_d        = avg_val_q;
      take_avg_commit = 1'b1;
    end else begin
      result_d = committed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_pos_q       <= '0;
      ring_fill_q      <= '0;
      avg_started_q    <= 1'b0;
      commit_started_q <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        ring_pos_q  <= ring_pos_d;
        ring_fill_q <= ring_fill_d;
      end
      if (cmd_i.mul) begin
        avg_started_q <= 1'b1;
      end
      if (cmd_i.band && take_avg_commit) begin
        commit_started_q <= 1'b1;
      end
      if (cmd_i.band) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_q  <= raw_sample_i;
      prev_q <= previous_output_i;
    end
    if (cmd_i.prep) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= ring_view[i];
      end
      filtered_q <= filtered_d;
    end
    if (cmd_i.mul) begin
      if (!avg_started_q) begin
        avg_s_q   <= AVG_W'(filtered_q) * AVG_W'(PERMILLE);
        avg_val_q <= filtered_q;
      end else begin
        fa_q <= AVG_W'(filtered_q) * AVG_W'(alpha_cap);
      end
    end
    if (cmd_i.sum) begin
      avg_s_q <= avg_new;
    end
    if (cmd_i.take_avg) begin
      avg_val_q <= VAL_W'(div_quot);
    end
    if (cmd_i.band && take_avg_commit) begin
      committed_q <= avg_val_q;
    end
    if (cmd_i.band) begin
      out_data_q <= result_d;
    end
  end

  assign status_o.avg_started = avg_started_q;
  assign status_o.div_done    = div_done;
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign conditioned_value_o = out_data_q;

  a_ring_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_pos_q != 2'd3)
    else $error("Ring position left the ring.");

  a_avg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_started_q |-> avg_val_q <= TOP_VALUE)
    else $error("Average integer part exceeds the full-scale value.");

  a_band_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.band |-> avg_started_q)
    else $error("Banding ran before the average was loaded.");

endmodule

>>> design/asc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditioner controller
// Sequences one sample through the datapath: prepare, multiply, divide by
// 1000, sum, divide again, banding; the first sample after reset skips divisions.
// ----------------------------------------------------------------------------
module asc_ctrl import asc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = status_i.avg_started ? ST_DIV_PROD : ST_BAND;
      end
      ST_DIV_PROD: begin
        if (status_i.div_done) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_DIV_SUM;
      end
      ST_DIV_SUM: begin
        if (status_i.div_done) begin
          state_d = ST_BAND;
        end
      end
      ST_BAND: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      ST_DIV_PROD: begin
        cmd_o = '0;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
      end
      ST_DIV_SUM: begin
        cmd_o.take_avg = status_i.div_done;
      end
      ST_BAND: begin
        cmd_o.band = !status_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_band_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BAND && status_i.out_busy) |=> state_q == ST_BAND)
    else $error("Result dropped while the output register was still full.");

endmodule

>>> tb/analog_sample_conditioner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Analog sample conditioner testbench
// Feeds converter samples through the sample channel under several register
// settings and checks every conditioned value against a cycle-free predictor
// of the clamp, median, average and banding chain. The sender works in bursts
// and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module analog_sample_conditioner_tb;
  import asc_pkg::*;

  localparam int unsigned SB          = SAMPLE_BITS_DEF;
  localparam int unsigned CFG_W       = (SB + 1 > ALPHA_W) ? SB + 1 : ALPHA_W;
  localparam int unsigned SAMPLE_MAX  = (1 << SB) - 1;
  localparam int unsigned TOP_VALUE   = 1 << SB;
  localparam int unsigned PREV_MAX    = (2 << SB) - 1;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 30;

  typedef enum int {PACE_NONE, PACE_LIGHT, PACE_HEAVY} pace_e;

  typedef struct packed {
    logic [SB-1:0] raw;
    logic [SB:0]   prev;
  } sample_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  asc_in_if  #(.SAMPLE_BITS(SB)) sample_if ();
  asc_out_if #(.SAMPLE_BITS(SB)) result_if ();
  asc_cfg_if #(.SAMPLE_BITS(SB)) cfg_if ();

  analog_sample_conditioner #(.SAMPLE_BITS(SB)) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  sample_item_t pending_samples[$];
  logic [SB:0]  expected_values[$];

  // Predictor copy of the registers and the filter state.
  logic [SB-1:0]      lo_limit  = '0;
  logic [SB-1:0]      hi_limit  = SB'(CLAMP_MAX_RST);
  logic [ALPHA_W-1:0] alpha_cfg = ALPHA_W'(SMOOTH_RST);
  logic [SB:0]        hyst_cfg  = '0;
  logic [SB:0]        dead_cfg  = '0;
  logic [SB:0]        ring_store [RING_DEPTH] = '{default: '0};
  int unsigned        ring_pos  = 0;
  int unsigned        ring_fill = 0;
  longint unsigned    avg_acc   = 0;
  bit                 avg_loaded  = 1'b0;
  bit                 commit_made = 1'b0;
  logic [SB:0]        commit_val  = '0;

  pace_e       send_pace = PACE_NONE;
  pace_e       take_pace = PACE_NONE;
  bit          sample_accepted = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned run_left   = 0;
  int unsigned hold_left  = 0;

  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned samples_taken  = 0;
  int unsigned values_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned held_hyst      = 0;
  int unsigned held_dead      = 0;
  int unsigned commits        = 0;

  function automatic logic [SB:0] abs_gap(input logic [SB:0] x, input logic [SB:0] y);
    return (x >= y) ? x - y : y - x;
  endfunction

  task automatic condition_sample(input logic [SB-1:0] raw, input logic [SB:0] prev,
                                  output logic [SB:0] value);
    logic [SB:0]     clamped;
    logic [SB:0]     a;
    logic [SB:0]     b;
    logic [SB:0]     c;
    logic [SB:0]     filt;
    logic [SB:0]     level;
    longint unsigned f;
    longint unsigned weight;
    // The lower limit is tested first, which matters when the limits cross.
    if (raw <= lo_limit) clamped = '0;
    else if (raw >= hi_limit) clamped = (SB + 1)'(TOP_VALUE);
    else clamped = {1'b0, raw};

    ring_store[ring_pos] = clamped;
    ring_pos = (ring_pos + 1) % RING_DEPTH;
    if (ring_fill < RING_DEPTH) ring_fill++;

    filt = clamped;
    if (ring_fill == RING_DEPTH) begin
      a = ring_store[0];
      b = ring_store[1];
      c = ring_store[2];
      if (a >= b) filt = (b >= c) ? b : ((a >= c) ? c : a);
      else filt = (a >= c) ? a : ((b >= c) ? c : b);
    end

    f = filt;
    weight = (alpha_cfg > PERMILLE) ? PERMILLE : alpha_cfg;
    if (!avg_loaded) begin
      avg_acc = f * PERMILLE;
      avg_loaded = 1'b1;
    end else begin
      avg_acc = (avg_acc * (PERMILLE - weight) + f * PERMILLE * weight) / PERMILLE;
    end
    level = (SB + 1)'(avg_acc / PERMILLE);

    if (abs_gap(level, prev) <= hyst_cfg) begin
      value = prev;
      held_hyst++;
    end else if (!commit_made) begin
      commit_made = 1'b1;
      commit_val = level;
      value = level;
      commits++;
    end else if (abs_gap(level, commit_val) <= dead_cfg) begin
      value = commit_val;
      held_dead++;
    end else begin
      commit_val = level;
      value = level;
      commits++;
    end
  endtask

  // Observes all three channels at the rising edge: register writes update the
  // predictor, results are checked before new expectations are queued.
  always @(posedge clk_i) begin
    logic [SB:0] want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        reg_writes++;
        case (cfg_if.index)
          REG_CLAMP_MIN:  lo_limit  = cfg_if.data[SB-1:0];
          REG_CLAMP_MAX:  hi_limit  = cfg_if.data[SB-1:0];
          REG_SMOOTHING:  alpha_cfg = cfg_if.data[ALPHA_W-1:0];
          REG_HYSTERESIS: hyst_cfg  = cfg_if.data[SB:0];
          REG_DEADBAND:   dead_cfg  = cfg_if.data[SB:0];
          default: ;
        endcase
      end
      if (result_if.valid && result_if.ready) begin
        values_checked++;
        if (expected_values.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected conditioned_value: expected none, actual %0d",
                   $time, result_if.conditioned_value);
        end else begin
          want = expected_values.pop_front();
          if (result_if.conditioned_value !== want) begin
            mismatches++;
            $display("%0t: conditioned_value mismatch: expected %0d, actual %0d",
                     $time, want, result_if.conditioned_value);
          end
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        condition_sample(sample_if.raw_sample, sample_if.previous_output, want);
        expected_values.push_back(want);
        samples_taken++;
        sample_accepted = 1'b1;
      end
    end
  end

  // Sample sender: bursts of transfers separated by random gaps. A gap only
  // starts after a transfer, so valid never drops while an item waits.
  always @(negedge clk_i) begin
    logic drive;
    drive = 1'b0;
    if (sample_accepted) begin
      sample_accepted = 1'b0;
      pending_samples.delete(0);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        case (send_pace)
          PACE_NONE:  gap_left = 0;
          PACE_LIGHT: gap_left = $urandom_range(0, 3);
          default:    gap_left = $urandom_range(0, 40);
        endcase
      end
    end
    if (gap_left > 0) gap_left--;
    else if (pending_samples.size() != 0) drive = 1'b1;
    sample_if.valid <= drive;
    if (drive) begin
      sample_if.raw_sample      <= pending_samples[0].raw;
      sample_if.previous_output <= pending_samples[0].prev;
    end
  end

  // Result receiver: runs of ready cycles broken by stalls of varying length.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left = $urandom_range(1, 12);
        case (take_pace)
          PACE_NONE:  hold_left = 0;
          PACE_LIGHT: hold_left = $urandom_range(0, 3);
          default:    hold_left = $urandom_range(0, 50);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[CFG_W-1:0];
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input int unsigned lo, input int unsigned hi,
                            input int unsigned al, input int unsigned hy,
                            input int unsigned db);
    write_reg(REG_CLAMP_MIN, lo);
    write_reg(REG_CLAMP_MAX, hi);
    write_reg(REG_SMOOTHING, al);
    write_reg(REG_HYSTERESIS, hy);
    write_reg(REG_DEADBAND, db);
  endtask

  task automatic push_sample(input int unsigned raw, input int unsigned prev);
    pending_samples.push_back('{raw: raw[SB-1:0], prev: prev[SB:0]});
  endtask

  // Waits until every queued sample has gone in and every result has come out.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_samples.size() != 0 || expected_values.size() != 0) @(posedge clk_i);
  endtask

  // A slowly wandering signal with converter noise, occasional spikes and
  // steps; the previous output mostly sits near the signal, as a caller's would.
  task automatic queue_signal(input int count);
    int level;
    int raw;
    int prev;
    int spread;
    level  = $urandom_range(0, SAMPLE_MAX);
    spread = $urandom_range(2, 40);
    repeat (count) begin
      if ($urandom_range(0, 31) == 0) level = $urandom_range(0, SAMPLE_MAX);
      else level += int'($urandom_range(0, 24)) - 12;
      if (level < 0) level = 0;
      if (level > int'(SAMPLE_MAX)) level = SAMPLE_MAX;
      case ($urandom_range(0, 15))
        0:       raw = $urandom_range(0, SAMPLE_MAX);
        1:       raw = $urandom_range(0, 1) ? 0 : SAMPLE_MAX;
        default: raw = level + int'($urandom_range(0, 6)) - 3;
      endcase
      if (raw < 0) raw = 0;
      if (raw > int'(SAMPLE_MAX)) raw = SAMPLE_MAX;
      if ($urandom_range(0, 3) == 0) begin
        prev = $urandom_range(0, PREV_MAX);
      end else begin
        prev = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (prev < 0) prev = 0;
        if (prev > int'(TOP_VALUE)) prev = TOP_VALUE;
      end
      push_sample(raw, prev);
    end
  endtask

  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned al;
    int unsigned hy;
    int unsigned db;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_CLAMP_MIN;
    cfg_if.data = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: first sample loads the average, the ring passes samples
    // through until full, then hysteresis, first commit and deadband hold.
    push_sample(0, 0);
    push_sample(SAMPLE_MAX, 0);
    push_sample(512, TOP_VALUE);
    push_sample(512, 512);
    push_sample(1, PREV_MAX);
    push_sample(SAMPLE_MAX - 1, TOP_VALUE);
    push_sample(SAMPLE_MAX, TOP_VALUE);
    push_sample(0, 1);
    wait_drained();

    // Crossed clamp limits, smoothing above the cap and stray register indexes.
    set_config(700, 300, ALPHA_W'('1), 5, 10);
    for (int k = int'(REG_DEADBAND) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), $urandom_range(0, PREV_MAX));
    push_sample(700, 0);
    push_sample(699, 0);
    push_sample(701, 0);
    push_sample(300, TOP_VALUE);
    push_sample(299, 0);
    push_sample(SAMPLE_MAX, PREV_MAX);
    push_sample(0, 0);
    wait_drained();

    // Everything clamps to zero, the average is frozen and both bands are wide.
    set_config(SAMPLE_MAX, 0, 0, TOP_VALUE, TOP_VALUE);
    push_sample(SAMPLE_MAX, 0);
    push_sample(0, TOP_VALUE);
    push_sample(512, PREV_MAX);
    wait_drained();

    send_pace = PACE_NONE;
    take_pace = PACE_NONE;
    set_config(0, SAMPLE_MAX, PERMILLE, 0, 0);
    queue_signal(100);
    wait_drained();

    send_pace = PACE_LIGHT;
    take_pace = PACE_LIGHT;
    set_config(50, 980, 250, 8, 4);
    queue_signal(150);
    wait_drained();

    send_pace = PACE_HEAVY;
    take_pace = PACE_NONE;
    set_config(0, SAMPLE_MAX, 0, TOP_VALUE, 0);
    queue_signal(60);
    wait_drained();

    send_pace = PACE_NONE;
    take_pace = PACE_HEAVY;
    set_config(SAMPLE_MAX, 0, 1, 0, TOP_VALUE);
    queue_signal(60);
    wait_drained();

    send_pace = PACE_HEAVY;
    take_pace = PACE_HEAVY;
    set_config(100, 900, 900, 3, 20);
    queue_signal(150);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SAMPLE_MAX) : $urandom_range(0, 200);
      hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SAMPLE_MAX)
                                       : $urandom_range(800, SAMPLE_MAX);
      al = $urandom_range(0, SAMPLE_MAX);
      hy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PREV_MAX) : $urandom_range(0, 24);
      db = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PREV_MAX) : $urandom_range(0, 24);
      // The ten-bit registers must drop a stray top data bit.
      if ($urandom_range(0, 1)) lo |= TOP_VALUE;
      if ($urandom_range(0, 1)) hi |= TOP_VALUE;
      if ($urandom_range(0, 1)) al |= TOP_VALUE;
      send_pace = pace_e'($urandom_range(0, 2));
      take_pace = pace_e'($urandom_range(0, 2));
      set_config(lo, hi, al, hy, db);
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_DEADBAND) + 1, (1 << CFG_IDX_W) - 1)),
                  $urandom_range(0, PREV_MAX));
      queue_signal(120);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d samples and checked %0d conditioned values across %0d register writes.",
             samples_taken, values_checked, reg_writes);
    $display("Predicted outcomes: %0d hysteresis holds, %0d deadband holds, %0d commits.",
             held_hyst, held_dead, commits);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
design/asc_pkg.sv
design/asc_in_if.sv
design/asc_out_if.sv
design/asc_cfg_if.sv
design/asc_div.sv
design/asc_dp.sv
design/asc_ctrl.sv
design/analog_sample_conditioner.sv
tb/analog_sample_conditioner_tb.sv
